// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the signed integer ALU.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an expression is never true outside of reset.
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

// ===== sv/sia_pkg.sv =====
`timescale 1ns / 1ps
// Package of the signed integer ALU: opcodes, field widths and the
// command word from controller to datapath. No dependencies.
package sia_pkg;

	localparam int RESULT_WIDTH  = 32;
	localparam int OPERAND_WIDTH = 32;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} dp_cmd_t;

endpackage

// ===== sv/sia_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the signed integer ALU: operand registers, shift-add multiply,
// restoring divide, sign fixup and result register. Depends on sia_pkg.
module sia_dp import sia_pkg::*; #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                            clk,
	input  logic [1:0]                      opcode,
	input  logic signed [OPERAND_WIDTH-1:0] operand_a,
	input  logic signed [OPERAND_WIDTH-1:0] operand_b,
	input  dp_cmd_t                         cmd,
	output logic signed [RESULT_WIDTH-1:0]  result
);

	localparam logic [WORD_WIDTH-1:0] WONE = WORD_WIDTH'(1);

	logic signed [WORD_WIDTH-1:0] a_w, b_w;
	logic [WORD_WIDTH-1:0]        a_u, b_u, mag_a, mag_b;
	logic [WORD_WIDTH-1:0]        acc_q, x_q, y_q;
	logic                         neg_q, bzero_q;
	op_t                          op_q;
	logic [RESULT_WIDTH-1:0]      result_q;
	logic [WORD_WIDTH:0]          rem_sh, diff;
	logic [WORD_WIDTH-1:0]        quot;

	assign a_w   = WORD_WIDTH'(operand_a);
	assign b_w   = WORD_WIDTH'(operand_b);
	assign a_u   = a_w;
	assign b_u   = b_w;
	assign mag_a = a_u[WORD_WIDTH-1] ? (~a_u + WONE) : a_u;
	assign mag_b = b_u[WORD_WIDTH-1] ? (~b_u + WONE) : b_u;

	assign rem_sh = {acc_q, x_q[WORD_WIDTH-1]};
	assign diff   = rem_sh - {1'b0, y_q};
	assign quot   = bzero_q ? '0 : (neg_q ? (~x_q + WONE) : x_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(opcode);
			neg_q   <= a_u[WORD_WIDTH-1] ^ b_u[WORD_WIDTH-1];
			bzero_q <= (b_u == '0);
			case (op_t'(opcode))
				OP_ADD: begin
					acc_q <= a_u + b_u;
					x_q   <= a_u;
					y_q   <= b_u;
				end
				OP_SUB: begin
					acc_q <= a_u - b_u;
					x_q   <= a_u;
					y_q   <= b_u;
				end
				OP_MUL: begin
					acc_q <= '0;
					x_q   <= a_u;
					y_q   <= b_u;
				end
				default: begin
					acc_q <= '0;
					x_q   <= mag_a;
					y_q   <= mag_b;
				end
			endcase
		end else if (cmd.step) begin
			if (op_q == OP_MUL) begin
				acc_q <= acc_q + (y_q[0] ? x_q : '0);
				x_q   <= {x_q[WORD_WIDTH-2:0], 1'b0};
				y_q   <= {1'b0, y_q[WORD_WIDTH-1:1]};
			end else if (!diff[WORD_WIDTH]) begin
				acc_q <= diff[WORD_WIDTH-1:0];
				x_q   <= {x_q[WORD_WIDTH-2:0], 1'b1};
			end else begin
				acc_q <= rem_sh[WORD_WIDTH-1:0];
				x_q   <= {x_q[WORD_WIDTH-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			if (op_q == OP_DIV) begin
				result_q <= RESULT_WIDTH'(quot);
			end else begin
				result_q <= RESULT_WIDTH'(acc_q);
			end
		end
	end

	assign result = result_q;

endmodule

// ===== sv/sia_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the signed integer ALU: state machine, step counter and
// output valid flag. Depends on sia_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sia_ctrl import sia_pkg::*; #(
	parameter int WORD_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	output logic       out_valid,
	input  logic       out_ready,
	output dp_cmd_t    cmd
);

	localparam int CW = $clog2(WORD_WIDTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_BUSY,
		S_FIX
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  cnt_q;
	logic           out_valid_q;
	logic           iterative;

	assign iterative  = (op_t'(opcode) == OP_MUL) || (op_t'(opcode) == OP_DIV);
	assign in_ready   = (state_q == S_IDLE);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.step   = (state_q == S_BUSY);
	assign cmd.finish = (state_q == S_FIX) && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						cnt_q   <= CW'(WORD_WIDTH - 1);
						state_q <= iterative ? S_BUSY : S_FIX;
					end
				end
				S_BUSY: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					if (cmd.finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_CLK(a_finish_free, cmd.finish |-> (!out_valid_q || out_ready), "result overwritten")
	`ASSERT_CLK(a_busy_end, (state_q == S_BUSY && cnt_q == '0) |=> (state_q == S_FIX), "step overrun")
	`ASSERT_NEVER(a_cmd_excl, cmd.load && (cmd.step || cmd.finish), "load during operation")

endmodule

// ===== sv/signed_integer_alu_core.sv =====
`timescale 1ns / 1ps
// Top level of the signed integer ALU: add, subtract, multiply, divide.
// Depends on sia_pkg, sia_ctrl and sia_dp.
//
//   channel  handshake              word
//   input    in_valid / in_ready    opcode, operand_a, operand_b
//   output   out_valid / out_ready  result
//
// Add and subtract: a word passes the fixup state into the output register.
// Multiply and divide: a word passes the busy state, where the radix-2 shift loop
// does one bit per cycle, then the fixup state into the output register.
// One word is in flight at a time; the next word is taken once the result
// has moved into the output register, even while that register waits.
// A stalled output holds the finished word in the fixup state.
// Reset clears controller state only; no clearing pass.
module signed_integer_alu_core import sia_pkg::*; #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      opcode,
	input  logic signed [OPERAND_WIDTH-1:0] operand_a,
	input  logic signed [OPERAND_WIDTH-1:0] operand_b,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [RESULT_WIDTH-1:0]  result
);

	dp_cmd_t cmd;

	sia_ctrl #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	sia_dp #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_dp (
		.clk      (clk),
		.opcode   (opcode),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.cmd      (cmd),
		.result   (result)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for signed_integer_alu_core: drives add, subtract, multiply
// and divide words, predicts each result, checks it in order amid random idle/stall.
// Depends on sia_pkg and signed_integer_alu_core.
module tb_top;
	import sia_pkg::*;

	localparam logic [31:0] MIN_VAL = 32'h8000_0000;
	localparam logic [31:0] MAX_VAL = 32'h7FFF_FFFF;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		op_t         op;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] value;
	} alu_word_t;

	class result_ledger;
		alu_word_t pending_results[$];
		int        mismatches;
		int        checked;

		function logic [31:0] alu_compute(op_t op, logic [31:0] a, logic [31:0] b);
			logic [31:0] mag_a;
			logic [31:0] mag_b;
			logic [31:0] quo;
			case (op)
				OP_ADD: return a + b;
				OP_SUB: return a - b;
				OP_MUL: return a * b;
				default: begin
					if (b == 32'd0)
						return 32'd0;
					mag_a = a[31] ? -a : a;
					mag_b = b[31] ? -b : b;
					quo = mag_a / mag_b;
					return (a[31] ^ b[31]) ? -quo : quo;
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			if (mismatches <= 100)
				$display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		function void note_word(op_t op, logic [31:0] a, logic [31:0] b);
			alu_word_t w;
			w.op = op;
			w.a = a;
			w.b = b;
			w.value = alu_compute(op, a, b);
			pending_results.push_back(w);
		endfunction

		task check_word(logic [31:0] got);
			alu_word_t w;
			checked++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %h with no word pending", got));
			end else begin
				w = pending_results.pop_front();
				if (got !== w.value)
					report_mismatch($sformatf("%s a=%h b=%h: result %h, want %h",
						w.op.name(), w.a, w.b, got, w.value));
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	op_t                opcode = OP_ADD;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] result;

	result_ledger ledger = new();
	int gap_pct = 0;
	int stall_pct = 0;
	logic hold_off = 1'b0;
	int sent_count = 0;
	int op_count[4] = '{0, 0, 0, 0};

	signed_integer_alu_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result   (result)
	);

	always #2 clk = ~clk;

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				ledger.check_word(result);
			if (hold_off)
				out_ready <= 1'b0;
			else
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// hold the output off long enough for the block to back up its input
	initial begin
		wait (sent_count >= 40);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (200) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#2000000;
		$display("signed_integer_alu_core regression: fail");
		$finish;
	end

	task automatic send_word(input op_t op, input logic [31:0] a, input logic [31:0] b);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(0, 99) < gap_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		ledger.note_word(op, a, b);
		op_count[op]++;
		sent_count++;
	endtask

	function automatic logic [31:0] rand_operand();
		logic [31:0] corners[7];
		corners = '{32'd0, 32'd1, 32'hFFFF_FFFF, MIN_VAL, MAX_VAL, MIN_VAL + 1, MAX_VAL - 1};
		case ($urandom_range(0, 9))
			0: return corners[$urandom_range(0, 6)];
			1, 2: return $urandom_range(0, 32) - 16;
			3: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic run_random(input int count, input int send_idle, input int recv_stall);
		gap_pct <= send_idle;
		stall_pct <= recv_stall;
		repeat (count)
			send_word(op_t'($urandom_range(0, 3)), rand_operand(), rand_operand());
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);

		send_word(OP_ADD, MAX_VAL, 32'd1);
		send_word(OP_ADD, MIN_VAL, MIN_VAL);
		send_word(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(OP_SUB, MIN_VAL, 32'd1);
		send_word(OP_SUB, 32'd0, MIN_VAL);
		send_word(OP_SUB, MAX_VAL, 32'hFFFF_FFFF);
		send_word(OP_MUL, MIN_VAL, 32'hFFFF_FFFF);
		send_word(OP_MUL, MAX_VAL, MAX_VAL);
		send_word(OP_MUL, 32'h0001_0000, 32'h0001_0000);
		send_word(OP_MUL, -32'sd7, 32'sd6);
		send_word(OP_MUL, 32'd0, MIN_VAL);
		send_word(OP_DIV, 32'd12345, 32'd0);
		send_word(OP_DIV, MIN_VAL, 32'd0);
		send_word(OP_DIV, MIN_VAL, 32'hFFFF_FFFF);
		send_word(OP_DIV, -32'sd7, 32'sd2);
		send_word(OP_DIV, 32'sd7, -32'sd2);
		send_word(OP_DIV, -32'sd7, -32'sd2);
		send_word(OP_DIV, MIN_VAL, 32'd1);
		send_word(OP_DIV, MIN_VAL, MIN_VAL);
		send_word(OP_DIV, MAX_VAL, MIN_VAL);
		send_word(OP_DIV, 32'd0, -32'sd5);
		send_word(OP_DIV, MAX_VAL, 32'd1);

		run_random(250, 0, 0);
		run_random(250, 71, 0);
		run_random(250, 0, 71);
		run_random(250, 14, 14);
		in_valid <= 1'b0;

		while (ledger.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d words (%0d add, %0d sub, %0d mul, %0d div) with idle and stall phases",
			sent_count, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV]);
		$display("checked %0d results, %0d mismatches", ledger.checked, ledger.mismatches);
		if (ledger.mismatches == 0)
			$display("signed_integer_alu_core regression: pass");
		else
			$display("signed_integer_alu_core regression: fail");
		$finish;
	end
endmodule
